// ===== rtl/ccenc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccenc_pkg
// Shared types and constants of the CRC codeword encoder: field widths,
// register reset values, configuration register indexes and the word record
// that travels down the cell chain.
// ----------------------------------------------------------------------------
package ccenc_pkg;

    // Field widths of the ports.
    localparam int DATA_W = 8;
    localparam int NIB_W  = 4;
    localparam int CW_W   = 24;
    localparam int CNT_W  = 5;
    localparam int GEN_W  = 17;
    localparam int GLEN_W = 5;
    localparam int IDX_W  = 2;

    // Width of the clamped generator length; covers lengths up to 63.
    localparam int LEN_W  = 6;

    // Register reset values.
    localparam logic [GEN_W-1:0]  GEN_BITS_RST = 17'd11;
    localparam logic [GLEN_W-1:0] GEN_LEN_RST  = 5'd4;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_GEN_BITS = 2'd0,
        REG_GEN_LEN  = 2'd1,
        REG_NIB_MODE = 2'd2
    } reg_idx_t;

    // One dataword in flight: a nibble dataword is carried zero-extended.
    typedef struct packed {
        logic              valid;
        logic              nib;
        logic              last;
        logic [DATA_W-1:0] data;
    } word_t;

endpackage

// ===== rtl/ccenc_feed.sv =====
// ----------------------------------------------------------------------------
// ccenc_feed
// Input side of the encoder. Turns each accepted byte into one dataword
// (byte mode) or two (nibble mode, high nibble first) and hands them to the
// first cell of the chain, one per cycle while the chain advances.
// ----------------------------------------------------------------------------
module ccenc_feed
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        nibble_mode,
    input  logic                        in_valid,
    input  logic [ccenc_pkg::DATA_W-1:0] data_byte,
    output logic                        in_stall,
    output ccenc_pkg::word_t            word_out
);

    logic                        pend_valid_reg;
    logic                        pend_valid_next;
    logic [ccenc_pkg::NIB_W-1:0] pend_nib_reg;
    logic [ccenc_pkg::NIB_W-1:0] pend_nib_next;

    // A pending low nibble goes first and holds off the next request.
    assign in_stall = !advance || pend_valid_reg;

    // Select the dataword that enters the chain this cycle.
    always_comb
    begin
        word_out        = '0;
        pend_valid_next = pend_valid_reg;
        pend_nib_next   = pend_nib_reg;
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                word_out.valid  = 1'b1;
                word_out.nib    = 1'b1;
                word_out.last   = 1'b1;
                word_out.data   = {{(ccenc_pkg::DATA_W - ccenc_pkg::NIB_W){1'b0}},
                                   pend_nib_reg};
                pend_valid_next = 1'b0;
            end
            else if (in_valid)
            begin
                word_out.valid = 1'b1;
                if (nibble_mode)
                begin
                    word_out.nib    = 1'b1;
                    word_out.last   = 1'b0;
                    word_out.data   = {{(ccenc_pkg::DATA_W - ccenc_pkg::NIB_W){1'b0}},
                                       data_byte[ccenc_pkg::DATA_W-1:ccenc_pkg::NIB_W]};
                    pend_valid_next = 1'b1;
                    pend_nib_next   = data_byte[ccenc_pkg::NIB_W-1:0];
                end
                else
                begin
                    word_out.nib  = 1'b0;
                    word_out.last = 1'b1;
                    word_out.data = data_byte;
                end
            end
        end
    end

    // Pending nibble register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_nib_reg <= pend_nib_next;
    end

endmodule

// ===== rtl/ccenc_cell.sv =====
// ----------------------------------------------------------------------------
// ccenc_cell
// One division step of the CRC. Takes one dataword bit, updates the running
// remainder and passes the word and remainder to the next cell.
// ----------------------------------------------------------------------------
module ccenc_cell
#(
    parameter int RW      = 16,
    parameter int BIT_SEL = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [RW-1:0]    rmask,
    input  logic [RW-1:0]    topmask,
    input  logic [RW-1:0]    gen_r,
    input  ccenc_pkg::word_t word_in,
    input  logic [RW-1:0]    rem_in,
    output ccenc_pkg::word_t word_out,
    output logic [RW-1:0]    rem_out
);

    logic                         valid_reg;
    logic                         nib_reg;
    logic                         last_reg;
    logic [ccenc_pkg::DATA_W-1:0] data_reg;
    logic [RW-1:0]                rem_reg;
    logic [RW-1:0]                rem_next;
    logic                         feedback;

    // Feedback is the data bit against the leading remainder bit.
    assign feedback = word_in.data[BIT_SEL] ^ (|(rem_in & topmask));
    assign rem_next = ((rem_in << 1) & rmask) ^ (feedback ? gen_r : '0);

    // Valid flag is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= word_in.valid;
        end
    end

    // Payload of the cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nib_reg  <= word_in.nib;
            last_reg <= word_in.last;
            data_reg <= word_in.data;
            rem_reg  <= rem_next;
        end
    end

    // Hand the word on to the next cell.
    always_comb
    begin
        word_out.valid = valid_reg;
        word_out.nib   = nib_reg;
        word_out.last  = last_reg;
        word_out.data  = data_reg;
    end

    assign rem_out = rem_reg;

endmodule

// ===== rtl/crc_codeword_encoder.sv =====
// ----------------------------------------------------------------------------
// crc_codeword_encoder
// Systematic CRC encoder with a configurable generator. Each byte yields one
// 8-bit dataword or two 4-bit datawords; each codeword is the dataword
// followed by its remainder, right-aligned.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    data_byte
//   out      output     out_valid / out_stall  codeword, codeword_bits, last
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A chain of eight cells takes one dataword per cycle unless stalled, one
// dataword bit per cell; byte mode sustains one byte per cycle, nibble mode
// takes no new byte while a low nibble holds the single dataword slot at
// the head of the chain. Results pass the eight cell registers and the
// output register; a low nibble's codeword comes right after the high's.
// Reset empties the chain and loads generator 1011, length 4, byte mode.
// A stall on a valid output freezes the whole chain and stalls the input.
// ----------------------------------------------------------------------------
module crc_codeword_encoder
#(
    parameter int MAX_GEN_LEN = 17
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ccenc_pkg::DATA_W-1:0] data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ccenc_pkg::CW_W-1:0]   codeword,
    output logic [ccenc_pkg::CNT_W-1:0]  codeword_bits,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ccenc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ccenc_pkg::GEN_W-1:0]  cfg_data
);

    localparam int RW    = MAX_GEN_LEN - 1;
    localparam int CELLS = ccenc_pkg::DATA_W;
    localparam int CWW   = (ccenc_pkg::DATA_W + RW > ccenc_pkg::CW_W) ?
                           (ccenc_pkg::DATA_W + RW) : ccenc_pkg::CW_W;

    logic [ccenc_pkg::GEN_W-1:0]  gen_bits_reg;
    logic [ccenc_pkg::GLEN_W-1:0] gen_len_reg;
    logic                         nib_mode_reg;

    logic [ccenc_pkg::LEN_W-1:0]  len_wide;
    logic [ccenc_pkg::LEN_W-1:0]  eff_len;
    logic [RW-1:0]                rmask;
    logic [RW-1:0]                topmask;
    logic [RW+ccenc_pkg::GEN_W-1:0] gen_wide;
    logic [RW-1:0]                gen_r;

    logic                         advance;
    ccenc_pkg::word_t             chain_word [0:CELLS];
    logic [RW-1:0]                chain_rem  [0:CELLS];

    logic [CWW-1:0]               data_wide;
    logic [CWW-1:0]               cw_full;
    logic [6:0]                   dsize;
    logic [6:0]                   bits_sum;

    logic                         out_valid_reg;
    logic [ccenc_pkg::CW_W-1:0]   codeword_reg;
    logic [ccenc_pkg::CW_W-1:0]   codeword_next;
    logic [ccenc_pkg::CNT_W-1:0]  bits_reg;
    logic [ccenc_pkg::CNT_W-1:0]  bits_next;
    logic                         last_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_bits_reg <= ccenc_pkg::GEN_BITS_RST;
            gen_len_reg  <= ccenc_pkg::GEN_LEN_RST;
            nib_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ccenc_pkg::REG_GEN_BITS: gen_bits_reg <= cfg_data;
                ccenc_pkg::REG_GEN_LEN:  gen_len_reg  <= cfg_data[ccenc_pkg::GLEN_W-1:0];
                ccenc_pkg::REG_NIB_MODE: nib_mode_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // Clamp the generator length to the supported range.
    always_comb
    begin
        len_wide = {1'b0, gen_len_reg};
        if (len_wide < 6'd2)
        begin
            eff_len = 6'd2;
        end
        else if (len_wide > 6'(MAX_GEN_LEN))
        begin
            eff_len = 6'(MAX_GEN_LEN);
        end
        else
        begin
            eff_len = len_wide;
        end
    end

    // Remainder mask, leading-bit mask and generator without its top bit.
    always_comb
    begin
        for (int i = 0; i < RW; i++)
        begin
            rmask[i]   = (6'(i) < (eff_len - 6'd1));
            topmask[i] = (6'(i) == (eff_len - 6'd2));
        end
    end

    assign gen_wide = {{RW{1'b0}}, gen_bits_reg};
    assign gen_r    = gen_wide[RW-1:0] & rmask;

    // The chain and output register move together.
    assign advance = !out_valid_reg || !out_stall;

    ccenc_feed u_feed
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .nibble_mode (nib_mode_reg),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .in_stall    (in_stall),
        .word_out    (chain_word[0])
    );

    assign chain_rem[0] = '0;

    // One cell per dataword bit, most significant bit first.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        ccenc_cell
        #(
            .RW      (RW),
            .BIT_SEL (CELLS - 1 - k)
        )
        u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .rmask    (rmask),
            .topmask  (topmask),
            .gen_r    (gen_r),
            .word_in  (chain_word[k]),
            .rem_in   (chain_rem[k]),
            .word_out (chain_word[k+1]),
            .rem_out  (chain_rem[k+1])
        );
    end

    // Assemble the codeword and its bit count.
    assign data_wide     = CWW'(chain_word[CELLS].data);
    assign cw_full       = (data_wide << (eff_len - 6'd1)) | CWW'(chain_rem[CELLS]);
    assign codeword_next = cw_full[ccenc_pkg::CW_W-1:0];
    assign dsize         = chain_word[CELLS].nib ? 7'(ccenc_pkg::NIB_W) :
                                                  7'(ccenc_pkg::DATA_W);
    assign bits_sum      = dsize + 7'(eff_len) - 7'd1;
    assign bits_next     = bits_sum[ccenc_pkg::CNT_W-1:0];

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_word[CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            codeword_reg <= codeword_next;
            bits_reg     <= bits_next;
            last_reg     <= chain_word[CELLS].last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign codeword      = codeword_reg;
    assign codeword_bits = bits_reg;
    assign last          = last_reg;

endmodule

// ===== tb/tb_crc_codeword_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_crc_codeword_encoder
// Self-checking testbench for the CRC codeword encoder. A predictor keeps its
// own copy of the generator registers and works out the codewords for every
// accepted request. Each codeword that the block delivers is compared field
// by field with the oldest prediction. The run covers directed extremes,
// random traffic under several generator settings with random idling on both
// channels, and a long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_crc_codeword_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN       = 17;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PERCENT  = 23;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASES        = 13;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [ccenc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    // One predicted codeword.
    typedef struct {
        logic [ccenc_pkg::CW_W-1:0]  cw;
        logic [ccenc_pkg::CNT_W-1:0] nbits;
        logic                        last;
    } codeword_rec_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [ccenc_pkg::DATA_W-1:0]  data_byte     = '0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [ccenc_pkg::CW_W-1:0]    codeword;
    logic [ccenc_pkg::CNT_W-1:0]   codeword_bits;
    logic                          last;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [ccenc_pkg::IDX_W-1:0]   cfg_index     = '0;
    logic [ccenc_pkg::GEN_W-1:0]   cfg_data      = '0;

    // Shadow copies of the generator registers.
    logic [ccenc_pkg::GEN_W-1:0]   gen_bits_q    = ccenc_pkg::GEN_BITS_RST;
    logic [ccenc_pkg::GLEN_W-1:0]  gen_len_q     = ccenc_pkg::GEN_LEN_RST;
    logic                          nibble_q      = 1'b0;

    codeword_rec_t       pending_codewords[$];
    int                  error_count   = 0;
    int                  cycle_count   = 0;
    bit                  idle_en       = 1'b1;
    int                  hold_len      = 0;
    int                  stall_left    = 0;

    crc_codeword_encoder #(.MAX_GEN_LEN(MAX_LEN)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .codeword      (codeword),
        .codeword_bits (codeword_bits),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Abort the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d codewords outstanding",
                     $time, pending_codewords.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Systematic CRC codeword of one dataword. Division steps fire on the
    // leading bit of the window, so a generator with leading zeros is XORed
    // in as given.
    function automatic logic [ccenc_pkg::CW_W-1:0] crc_codeword(
        input logic [ccenc_pkg::DATA_W-1:0] data,
        input int unsigned                  dsize,
        input int unsigned                  glen,
        input logic [ccenc_pkg::GEN_W-1:0]  gbits);
        logic [31:0] gen;
        logic [31:0] dword;
        logic [31:0] window;
        int unsigned n;
        int unsigned i;
        n      = dsize + glen - 1;
        gen    = 32'(gbits) & ((32'd1 << glen) - 1);
        dword  = 32'(data) & ((32'd1 << dsize) - 1);
        window = dword << (glen - 1);
        for (i = 0; i < dsize; i++)
        begin
            if (window[n - 1 - i])
                window = window ^ (gen << (dsize - 1 - i));
        end
        return ccenc_pkg::CW_W'((dword << (glen - 1)) |
                                (window & ((32'd1 << (glen - 1)) - 1)));
    endfunction

    // Predict the codewords that one accepted byte produces.
    task automatic queue_codewords_for(input logic [ccenc_pkg::DATA_W-1:0] b);
        int unsigned   glen;
        codeword_rec_t rec;
        glen = gen_len_q;
        if (glen < 2)
            glen = 2;
        if (glen > MAX_LEN)
            glen = MAX_LEN;
        if (nibble_q)
        begin
            rec.cw    = crc_codeword(ccenc_pkg::DATA_W'(b[7:4]), ccenc_pkg::NIB_W, glen,
                                     gen_bits_q);
            rec.nbits = ccenc_pkg::CNT_W'(ccenc_pkg::NIB_W + glen - 1);
            rec.last  = 1'b0;
            pending_codewords.push_back(rec);
            rec.cw    = crc_codeword(ccenc_pkg::DATA_W'(b[3:0]), ccenc_pkg::NIB_W, glen,
                                     gen_bits_q);
            rec.last  = 1'b1;
            pending_codewords.push_back(rec);
        end
        else
        begin
            rec.cw    = crc_codeword(b, ccenc_pkg::DATA_W, glen, gen_bits_q);
            rec.nbits = ccenc_pkg::CNT_W'(ccenc_pkg::DATA_W + glen - 1);
            rec.last  = 1'b1;
            pending_codewords.push_back(rec);
        end
    endtask

    // Output side: check each delivered codeword and choose the next stall.
    always @(posedge clk)
    begin
        codeword_rec_t rec;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_codewords.size() == 0)
            begin
                $display("%0t: unexpected codeword, expected none, actual %h",
                         $time, codeword);
                error_count++;
            end
            else
            begin
                rec = pending_codewords.pop_front();
                if (codeword !== rec.cw)
                begin
                    $display("%0t: codeword mismatch, expected %h, actual %h",
                             $time, rec.cw, codeword);
                    error_count++;
                end
                if (codeword_bits !== rec.nbits)
                begin
                    $display("%0t: codeword_bits mismatch, expected %0d, actual %0d",
                             $time, rec.nbits, codeword_bits);
                    error_count++;
                end
                if (last !== rec.last)
                begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, rec.last, last);
                    error_count++;
                end
            end
        end
        if (hold_len != 0)
        begin
            stall_left = hold_len;
            hold_len   = 0;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= idle_en && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Write one register and track it in the shadow copy. The caller lowers
    // cfg_valid once its writes are done.
    task automatic write_register(input logic [ccenc_pkg::IDX_W-1:0] idx,
                                  input logic [ccenc_pkg::GEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ccenc_pkg::REG_GEN_BITS: gen_bits_q = value;
            ccenc_pkg::REG_GEN_LEN:  gen_len_q  = value[ccenc_pkg::GLEN_W-1:0];
            ccenc_pkg::REG_NIB_MODE: nibble_q   = value[0];
            default:                 ;
        endcase
    endtask

    task automatic apply_config(input logic [ccenc_pkg::GEN_W-1:0]  gbits,
                                input logic [ccenc_pkg::GLEN_W-1:0] glen,
                                input logic                         nib);
        write_register(ccenc_pkg::REG_GEN_BITS, gbits);
        write_register(ccenc_pkg::REG_GEN_LEN, ccenc_pkg::GEN_W'(glen));
        write_register(ccenc_pkg::REG_NIB_MODE, ccenc_pkg::GEN_W'(nib));
        cfg_valid <= 1'b0;
    endtask

    // Offer one byte, with an optional random gap first, until accepted.
    task automatic send_byte(input logic [ccenc_pkg::DATA_W-1:0] b);
        while (idle_en && ($urandom_range(99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_codewords_for(b);
    endtask

    // Stop offering and let every predicted codeword come out.
    task automatic wait_for_results;
        in_valid <= 1'b0;
        while (pending_codewords.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset register values in byte mode, with byte extremes.
    task automatic test_reset_defaults;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(8'hAA);
        wait_for_results();
    endtask

    // Two codewords per byte, high nibble first.
    task automatic test_nibble_mode;
        apply_config(ccenc_pkg::GEN_BITS_RST, ccenc_pkg::GEN_LEN_RST, 1'b1);
        send_byte(8'hF0);
        send_byte(8'h0F);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        wait_for_results();
    endtask

    // Clamped lengths, widest codewords, zero and leading-zero generators.
    task automatic test_generator_extremes;
        write_register(REG_UNUSED, ccenc_pkg::GEN_W'($urandom_range(17'h1FFFF)));
        apply_config(17'h00003, 5'd0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h80);
        wait_for_results();
        apply_config(17'h00001, 5'd1, 1'b1);
        send_byte(8'hA5);
        wait_for_results();
        apply_config(17'h1FFFF, 5'd17, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h01);
        wait_for_results();
        apply_config(17'h1FFFF, 5'd31, 1'b1);
        send_byte(8'hFF);
        wait_for_results();
        apply_config(17'h0000B, 5'd8, 1'b0);
        send_byte(8'hC3);
        wait_for_results();
        apply_config(17'h00000, 5'd5, 1'b0);
        send_byte(8'h7E);
        wait_for_results();
        apply_config(17'h15555, 5'd16, 1'b1);
        send_byte(8'h3C);
        wait_for_results();
    endtask

    // Random bytes under a fresh random setting per phase; one phase runs
    // with no idling on either side.
    task automatic test_random_traffic;
        int                            phase;
        int                            k;
        logic [ccenc_pkg::GLEN_W-1:0]  glen;
        for (phase = 0; phase < PHASES; phase++)
        begin
            idle_en = (phase != PHASES / 2);
            if ($urandom_range(9) < 7)
                glen = ccenc_pkg::GLEN_W'($urandom_range(MAX_LEN, 2));
            else
                glen = ccenc_pkg::GLEN_W'($urandom_range(31));
            apply_config(ccenc_pkg::GEN_W'($urandom_range(17'h1FFFF)), glen,
                         1'($urandom_range(1)));
            for (k = 0; k < PHASE_ITEMS; k++)
                send_byte(ccenc_pkg::DATA_W'($urandom_range(255)));
            wait_for_results();
        end
        idle_en = 1'b1;
    endtask

    // Long output hold while requests keep coming, so the chain fills and
    // stalls its input; then the sender waits for every codeword.
    task automatic test_backpressure;
        int k;
        apply_config(ccenc_pkg::GEN_W'($urandom_range(17'h1FFFF)),
                     ccenc_pkg::GLEN_W'($urandom_range(MAX_LEN, 2)), 1'b1);
        hold_len = 120;
        for (k = 0; k < 40; k++)
            send_byte(ccenc_pkg::DATA_W'($urandom_range(255)));
        wait_for_results();
    endtask

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_nibble_mode();
        test_generator_extremes();
        test_random_traffic();
        test_backpressure();
        wait_for_results();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
